// ----- hw/rtl/dlps_pkg.sv -----
// shared types and constants for the direct laplace potential sum block
// no dependencies; used by every module of the block
package dlps_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_EVAL  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_SCALE,
      ST_FINAL
   } state_type;

   // control tag carried alongside each source through the pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic skip;
      logic neg;
   } tag_type;

   // 1/(4*pi) in q0.32
   localparam logic [28:0] INV_FOUR_PI_Q32 = 29'd341782638;

   localparam int POT_W     = 48;
   localparam int DENS_W    = 32;
   localparam int ACC_W     = 63;
   localparam int NUM_SHIFT = 29;

endpackage

// ----- hw/rtl/dlps_sqrt_cell.sv -----
// one cell of the integer square root chain, one root bit per cell
// depends on dlps_pkg for the tag type
module dlps_sqrt_cell #(
   parameter int R_W   = 26,
   parameter int PAY_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dlps_pkg::tag_type     tag_i,
   input  logic [PAY_W-1:0]      pay_i,
   input  logic [2*R_W-1:0]      rad_i,
   input  logic [R_W+2:0]        rem_i,
   input  logic [R_W-1:0]        root_i,
   output dlps_pkg::tag_type     tag_o,
   output logic [PAY_W-1:0]      pay_o,
   output logic [2*R_W-1:0]      rad_o,
   output logic [R_W+2:0]        rem_o,
   output logic [R_W-1:0]        root_o
);

   localparam int REM_W = R_W + 3;

   logic [REM_W-1:0] rem2;
   logic [REM_W-1:0] trial;
   logic             ge;

   assign rem2  = {rem_i[REM_W-3:0], rad_i[2*R_W-1 -: 2]};
   assign trial = {1'b0, root_i, 2'b01};
   assign ge    = (rem2 >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_o <= '0;
      end else begin
         tag_o <= tag_i;
      end
      pay_o  <= pay_i;
      rad_o  <= {rad_i[2*R_W-3:0], 2'b00};
      rem_o  <= ge ? (rem2 - trial) : rem2;
      root_o <= {root_i[R_W-2:0], ge};
   end

endmodule

// ----- hw/rtl/dlps_div_cell.sv -----
// one cell of the restoring divider chain, one quotient bit per cell
// depends on dlps_pkg for the tag type
module dlps_div_cell #(
   parameter int D_W = 26,
   parameter int N_W = 61
) (
   input  logic               clock,
   input  logic               reset,
   input  dlps_pkg::tag_type  tag_i,
   input  logic [D_W-1:0]     div_i,
   input  logic [D_W-1:0]     rem_i,
   input  logic [N_W-1:0]     num_i,
   input  logic [N_W-1:0]     q_i,
   output dlps_pkg::tag_type  tag_o,
   output logic [D_W-1:0]     div_o,
   output logic [D_W-1:0]     rem_o,
   output logic [N_W-1:0]     num_o,
   output logic [N_W-1:0]     q_o
);

   logic [D_W:0] rem2;
   logic [D_W:0] dv;
   logic [D_W:0] diff;
   logic         ge;

   assign rem2 = {rem_i, num_i[N_W-1]};
   assign dv   = {1'b0, div_i};
   assign ge   = (rem2 >= dv);
   assign diff = rem2 - dv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_o <= '0;
      end else begin
         tag_o <= tag_i;
      end
      div_o <= div_i;
      rem_o <= ge ? diff[D_W-1:0] : rem2[D_W-1:0];
      num_o <= {num_i[N_W-2:0], 1'b0};
      q_o   <= {q_i[N_W-2:0], ge};
   end

endmodule

// ----- hw/rtl/dlps_term_pipe.sv -----
// per-source term pipeline: distance, square root chain, divider chain
// depends on dlps_pkg, dlps_sqrt_cell and dlps_div_cell
module dlps_term_pipe #(
   parameter int COORD_BITS = 24,
   parameter int DIST_SHIFT = 0,
   parameter int MAG_W      = 25,
   parameter int R_W        = 26,
   parameter int N_W        = 61
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dlps_pkg::tag_type            in_tag,
   input  logic signed [COORD_BITS-1:0] src_x,
   input  logic signed [COORD_BITS-1:0] src_y,
   input  logic signed [COORD_BITS-1:0] src_z,
   input  logic signed [31:0]           src_dens,
   input  logic signed [COORD_BITS-1:0] tgt_x,
   input  logic signed [COORD_BITS-1:0] tgt_y,
   input  logic signed [COORD_BITS-1:0] tgt_z,
   output dlps_pkg::tag_type            out_tag,
   output logic [N_W-1:0]               out_q
);

   localparam int REM_W = R_W + 3;
   localparam int PAD_W = dlps_pkg::NUM_SHIFT - DIST_SHIFT;

   logic signed [COORD_BITS:0] dx, dy, dz;
   logic [COORD_BITS:0]        mx, my, mz;
   logic [31:0]                dmag;

   // stage a: differences and magnitudes
   dlps_pkg::tag_type a_tag_ff;
   logic [MAG_W-1:0]  ax_ff, ay_ff, az_ff;
   logic [31:0]       a_dmag_ff;
   // stage b: squares
   dlps_pkg::tag_type b_tag_ff;
   logic [2*MAG_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [31:0]        b_dmag_ff;
   // stage c: distance squared
   dlps_pkg::tag_type c_tag_ff;
   logic [2*R_W-1:0]  c_sum_ff;
   logic [31:0]       c_dmag_ff;

   assign dx   = {tgt_x[COORD_BITS-1], tgt_x} - {src_x[COORD_BITS-1], src_x};
   assign dy   = {tgt_y[COORD_BITS-1], tgt_y} - {src_y[COORD_BITS-1], src_y};
   assign dz   = {tgt_z[COORD_BITS-1], tgt_z} - {src_z[COORD_BITS-1], src_z};
   assign mx   = dx[COORD_BITS] ? -dx : dx;
   assign my   = dy[COORD_BITS] ? -dy : dy;
   assign mz   = dz[COORD_BITS] ? -dz : dz;
   assign dmag = src_dens[31] ? 32'd0 - src_dens : src_dens;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
      end else begin
         a_tag_ff <= {in_tag.valid, in_tag.last,
                      (dx == '0) && (dy == '0) && (dz == '0), src_dens[31]};
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
      end
      ax_ff     <= mx[COORD_BITS:DIST_SHIFT];
      ay_ff     <= my[COORD_BITS:DIST_SHIFT];
      az_ff     <= mz[COORD_BITS:DIST_SHIFT];
      a_dmag_ff <= dmag;
      sqx_ff    <= ax_ff * ax_ff;
      sqy_ff    <= ay_ff * ay_ff;
      sqz_ff    <= az_ff * az_ff;
      b_dmag_ff <= a_dmag_ff;
      c_sum_ff  <= {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
      c_dmag_ff <= b_dmag_ff;
   end

   // square root chain
   dlps_pkg::tag_type s_tag  [R_W+1];
   logic [31:0]       s_pay  [R_W+1];
   logic [2*R_W-1:0]  s_rad  [R_W+1];
   logic [REM_W-1:0]  s_rem  [R_W+1];
   logic [R_W-1:0]    s_root [R_W+1];

   assign s_tag[0]  = c_tag_ff;
   assign s_pay[0]  = c_dmag_ff;
   assign s_rad[0]  = c_sum_ff;
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar k = 0; k < R_W; k++) begin : g_sqrt
      dlps_sqrt_cell #(.R_W(R_W), .PAY_W(32)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tag_i  (s_tag[k]),
         .pay_i  (s_pay[k]),
         .rad_i  (s_rad[k]),
         .rem_i  (s_rem[k]),
         .root_i (s_root[k]),
         .tag_o  (s_tag[k+1]),
         .pay_o  (s_pay[k+1]),
         .rad_o  (s_rad[k+1]),
         .rem_o  (s_rem[k+1]),
         .root_o (s_root[k+1])
      );
   end

   // divisor prep: a rounded-away distance counts as one
   dlps_pkg::tag_type p_tag_ff;
   logic [R_W-1:0]    p_div_ff;
   logic [N_W-1:0]    p_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_tag_ff <= '0;
      end else begin
         p_tag_ff <= s_tag[R_W];
      end
      p_div_ff <= (s_root[R_W] == '0) ? R_W'(1) : s_root[R_W];
      p_num_ff <= {s_pay[R_W], {PAD_W{1'b0}}};
   end

   // divider chain
   dlps_pkg::tag_type d_tag [N_W+1];
   logic [R_W-1:0]    d_div [N_W+1];
   logic [R_W-1:0]    d_rem [N_W+1];
   logic [N_W-1:0]    d_num [N_W+1];
   logic [N_W-1:0]    d_q   [N_W+1];

   assign d_tag[0] = p_tag_ff;
   assign d_div[0] = p_div_ff;
   assign d_rem[0] = '0;
   assign d_num[0] = p_num_ff;
   assign d_q[0]   = '0;

   for (genvar k = 0; k < N_W; k++) begin : g_div
      dlps_div_cell #(.D_W(R_W), .N_W(N_W)) u_cell (
         .clock (clock),
         .reset (reset),
         .tag_i (d_tag[k]),
         .div_i (d_div[k]),
         .rem_i (d_rem[k]),
         .num_i (d_num[k]),
         .q_i   (d_q[k]),
         .tag_o (d_tag[k+1]),
         .div_o (d_div[k+1]),
         .rem_o (d_rem[k+1]),
         .num_o (d_num[k+1]),
         .q_o   (d_q[k+1])
      );
   end

   assign out_tag = d_tag[N_W];
   assign out_q   = d_q[N_W];

endmodule

// ----- hw/rtl/direct_laplace_potential_sum_top.sv -----
// an evaluation reads one source per cycle from the source store into the pipeline, whose depth
// is set by the square root chain (COORD_BITS+2 cells) and divider chain (61 cells), then two
// scale steps lead to the result strobe
// an empty store goes straight to the scale steps; one evaluation at a time
// load, clear and no-op transactions finish without leaving idle; the receiver cannot stall the strobe
// synchronous active-high reset empties the store and idles the sequencer, no clearing pass
// top level: source store, sequencer, accumulator and final scaling
// depends on dlps_pkg and dlps_term_pipe
module direct_laplace_potential_sum_top #(
   parameter int MAX_SOURCES = 1024,
   parameter int COORD_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic signed [31:0]           req_density,
   input  logic signed [47:0]           req_start_potential,
   output logic                         rsp_valid,
   output logic signed [47:0]           rsp_potential,
   output logic                         rsp_overflow
);

   // derived widths
   localparam int DIST_SHIFT = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
   localparam int MAG_W      = COORD_BITS + 1 - DIST_SHIFT;
   localparam int R_W        = MAG_W + 1;
   localparam int N_W        = dlps_pkg::DENS_W + dlps_pkg::NUM_SHIFT - DIST_SHIFT;
   localparam int AW         = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CW         = $clog2(MAX_SOURCES + 1);
   localparam int ACC_W      = dlps_pkg::ACC_W;

   // source store, written on load transactions, read one entry a cycle
   logic signed [COORD_BITS-1:0] mem_x [MAX_SOURCES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_SOURCES];
   logic signed [COORD_BITS-1:0] mem_z [MAX_SOURCES];
   logic signed [31:0]           mem_d [MAX_SOURCES];

   dlps_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       j_ff, j_in;
   logic                mem_we;
   logic                tgt_we;
   dlps_pkg::tag_type   issue;
   dlps_pkg::tag_type   rd_tag_ff;

   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic signed [31:0]           rd_d_ff;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic signed [47:0]           start_pot_ff;

   dlps_pkg::tag_type term_tag;
   logic [N_W-1:0]    term_q;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic signed [63:0]      acc_sum;
   logic [63:0]             term_ext;
   logic signed [ACC_W-1:0] acc_next;
   logic                    acc_sat;

   // final scaling
   logic [ACC_W-1:0]   acc_mag;
   logic [59:0]        prodh_ff;
   logic [60:0]        prodl_ff;
   logic               acc_neg_ff;
   logic [60:0]        prod;
   logic signed [63:0] scaled;
   logic signed [63:0] total;
   logic               pot_sat;
   logic signed [47:0] pot_clamped;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_pot_ff, rsp_pot_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [1:0] act;
   assign act = req_action;

   // accumulate one term, clamped to the accumulator range
   assign term_ext = {{(64 - N_W){1'b0}}, term_q};
   assign acc_sum  = term_tag.neg ? {acc_ff[ACC_W-1], acc_ff} - $signed(term_ext)
                                  : {acc_ff[ACC_W-1], acc_ff} + $signed(term_ext);
   assign acc_sat  = acc_sum[63] != acc_sum[62];
   always_comb begin
      if (!acc_sat) begin
         acc_next = acc_sum[ACC_W-1:0];
      end else if (acc_sum[63]) begin
         acc_next = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_next = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   // magnitude scaled by 1/(4*pi) as two partial products
   assign acc_mag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign prod    = {1'b0, prodh_ff} + {32'd0, prodl_ff[60:32]};
   assign scaled  = acc_neg_ff ? 64'sd0 - $signed({3'b000, prod})
                               : $signed({3'b000, prod});
   assign total   = scaled + {{16{start_pot_ff[47]}}, start_pot_ff};
   assign pot_sat = (total[63:47] != '0) && (total[63:47] != '1);
   always_comb begin
      if (!pot_sat) begin
         pot_clamped = total[47:0];
      end else if (total[63]) begin
         pot_clamped = {1'b1, 47'd0};
      end else begin
         pot_clamped = {1'b0, {47{1'b1}}};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      j_in         = j_ff;
      mem_we       = 1'b0;
      tgt_we       = 1'b0;
      issue        = '0;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_pot_in   = rsp_pot_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (term_tag.valid && !term_tag.skip) begin
         acc_in = acc_next;
         ovf_in = ovf_ff | acc_sat;
      end

      unique case (state_ff)
         dlps_pkg::ST_IDLE: begin
            if (start) begin
               unique case (dlps_pkg::action_type'(act))
                  dlps_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  dlps_pkg::ACT_LOAD: begin
                     if (count_ff < CW'(MAX_SOURCES)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  dlps_pkg::ACT_EVAL: begin
                     tgt_we   = 1'b1;
                     acc_in   = '0;
                     ovf_in   = 1'b0;
                     j_in     = '0;
                     state_in = (count_ff == '0) ? dlps_pkg::ST_SCALE : dlps_pkg::ST_RUN;
                  end
                  dlps_pkg::ACT_NOP: begin
                  end
               endcase
            end
         end
         dlps_pkg::ST_RUN: begin
            issue.valid = 1'b1;
            issue.last  = (j_ff == count_ff - CW'(1));
            j_in        = j_ff + CW'(1);
            if (issue.last) begin
               state_in = dlps_pkg::ST_WAIT;
            end
         end
         dlps_pkg::ST_WAIT: begin
            if (term_tag.valid && term_tag.last) begin
               state_in = dlps_pkg::ST_SCALE;
            end
         end
         dlps_pkg::ST_SCALE: begin
            state_in = dlps_pkg::ST_FINAL;
         end
         dlps_pkg::ST_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_pot_in   = pot_clamped;
            rsp_ovf_in   = ovf_ff | pot_sat;
            state_in     = dlps_pkg::ST_IDLE;
         end
         default: begin
            state_in = dlps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlps_pkg::ST_IDLE;
         count_ff     <= '0;
         j_ff         <= '0;
         rd_tag_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         j_ff         <= j_in;
         rd_tag_ff    <= issue;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff     <= acc_in;
      rsp_pot_ff <= rsp_pot_in;
      rsp_ovf_ff <= rsp_ovf_in;
      prodh_ff   <= acc_mag[ACC_W-1:32] * dlps_pkg::INV_FOUR_PI_Q32;
      prodl_ff   <= acc_mag[31:0] * dlps_pkg::INV_FOUR_PI_Q32;
      acc_neg_ff <= acc_ff[ACC_W-1];
      if (tgt_we) begin
         tgt_x_ff     <= req_pos_x;
         tgt_y_ff     <= req_pos_y;
         tgt_z_ff     <= req_pos_z;
         start_pot_ff <= req_start_potential;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[count_ff[AW-1:0]] <= req_pos_x;
         mem_y[count_ff[AW-1:0]] <= req_pos_y;
         mem_z[count_ff[AW-1:0]] <= req_pos_z;
         mem_d[count_ff[AW-1:0]] <= req_density;
      end
      rd_x_ff <= mem_x[j_ff[AW-1:0]];
      rd_y_ff <= mem_y[j_ff[AW-1:0]];
      rd_z_ff <= mem_z[j_ff[AW-1:0]];
      rd_d_ff <= mem_d[j_ff[AW-1:0]];
   end

   dlps_term_pipe #(
      .COORD_BITS (COORD_BITS),
      .DIST_SHIFT (DIST_SHIFT),
      .MAG_W      (MAG_W),
      .R_W        (R_W),
      .N_W        (N_W)
   ) u_term (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .src_x    (rd_x_ff),
      .src_y    (rd_y_ff),
      .src_z    (rd_z_ff),
      .src_dens (rd_d_ff),
      .tgt_x    (tgt_x_ff),
      .tgt_y    (tgt_y_ff),
      .tgt_z    (tgt_z_ff),
      .out_tag  (term_tag),
      .out_q    (term_q)
   );

   assign busy          = (state_ff != dlps_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_potential = rsp_pot_ff;
   assign rsp_overflow  = rsp_ovf_ff;

`ifndef SYNTH
   // a result only follows the final scaling step
   a_rsp_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == dlps_pkg::ST_FINAL)
      else $error("result strobe without final step");

   // the store never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SOURCES))
      else $error("source count beyond store depth");

   // the last term of an evaluation only arrives while waiting for it
   a_last_in_wait: assert property (@(posedge clock) disable iff (reset)
      (term_tag.valid && term_tag.last) |-> state_ff == dlps_pkg::ST_WAIT)
      else $error("last term outside wait state");
`endif

endmodule
